// ===== design/idal_pkg.sv =====
`default_nettype none

package idal_pkg;

   localparam int ID_BITS  = 10;
   localparam int ID_SPACE = 1 << ID_BITS;

   localparam logic [1:0] STATUS_ISSUED    = 2'd0;
   localparam logic [1:0] STATUS_RELEASED  = 2'd1;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

   localparam logic FUNC_REQUEST = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef logic [ID_BITS-1:0] id_type;
   typedef logic [ID_BITS:0]   count_type;
   typedef logic [1:0]         status_type;

endpackage

`default_nettype wire

// ===== design/idal_if.sv =====
`default_nettype none

interface idal_req_if;
   logic             valid;
   logic             ready;
   logic             func;
   idal_pkg::id_type release_id;

   modport source (output valid, output func, output release_id, input ready);
   modport sink   (input valid, input func, input release_id, output ready);
endinterface

interface idal_rsp_if;
   logic                 valid;
   logic                 ready;
   idal_pkg::id_type     id;
   idal_pkg::status_type status;

   modport source (output valid, output id, output status, input ready);
   modport sink   (input valid, input id, input status, output ready);
endinterface

`default_nettype wire

// ===== design/id_allocator_fifo_free_list_top.sv =====
// Channel   Dir  Payload                 Transfer
// req_chan  in   func, release_id        valid && ready
// rsp_chan  out  id, status              valid && ready
//
// For each item the transfer cycle reads the free queue and the membership
// memory; the execute state then uses the read data, writes back and loads the
// result register. No new transfer is taken until that write-back is done.
// After reset a clearing pass (one membership entry a cycle) runs before the
// first request transfer is taken.
// A stalled result holds the next item in its execute state until the result is taken.
`default_nettype none

module id_allocator_fifo_free_list_top (
   input wire logic    clock,
   input wire logic    reset,
   idal_req_if.sink    req_chan,
   idal_rsp_if.source  rsp_chan
);
   import idal_pkg::*;

   typedef enum logic [2:0] {
      FSM_CLEAR = 3'b001,
      FSM_IDLE  = 3'b010,
      FSM_EXEC  = 3'b100
   } fsm_type;

   fsm_type    state_ff, state_in;
   id_type     clr_idx_ff, clr_idx_in;
   count_type  fresh_ff, fresh_in;
   id_type     head_ff, head_in;
   id_type     tail_ff, tail_in;
   count_type  count_ff, count_in;
   logic       func_ff, func_in;
   id_type     rel_ff, rel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   id_type     rsp_id_ff, rsp_id_in;
   status_type rsp_status_ff, rsp_status_in;

   logic   accept;
   logic   out_free;
   logic   q_wr_en;
   id_type q_rd_data;
   logic   mark_wr_en;
   id_type mark_wr_addr;
   logic   mark_wr_data;
   logic   mark_rd_data;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready  = (state_ff == FSM_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.id     = rsp_id_ff;
   assign rsp_chan.status = rsp_status_ff;

   idal_ram #(.WIDTH(ID_BITS), .DEPTH(ID_SPACE)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff),
      .wr_data (rel_ff),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   idal_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (accept),
      .rd_addr (req_chan.release_id),
      .rd_data (mark_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      fresh_in      = fresh_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      func_in       = func_ff;
      rel_in        = rel_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      q_wr_en       = 1'b0;
      mark_wr_en    = 1'b0;
      mark_wr_addr  = rel_ff;
      mark_wr_data  = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         FSM_CLEAR: begin
            mark_wr_en   = 1'b1;
            mark_wr_addr = clr_idx_ff;
            clr_idx_in   = clr_idx_ff + 1'b1;
            if (clr_idx_ff == {ID_BITS{1'b1}}) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (accept) begin
               func_in  = req_chan.func;
               rel_in   = req_chan.release_id;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (out_free) begin
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               if (func_ff == FUNC_REQUEST) begin
                  if (count_ff != '0) begin
                     rsp_id_in     = q_rd_data;
                     rsp_status_in = STATUS_ISSUED;
                     head_in       = head_ff + 1'b1;
                     count_in      = count_ff - 1'b1;
                     mark_wr_en    = 1'b1;
                     mark_wr_addr  = q_rd_data;
                     mark_wr_data  = 1'b0;
                  end else if (!fresh_ff[ID_BITS]) begin
                     rsp_id_in     = fresh_ff[ID_BITS-1:0];
                     rsp_status_in = STATUS_ISSUED;
                     fresh_in      = fresh_ff + 1'b1;
                  end else begin
                     rsp_id_in     = '0;
                     rsp_status_in = STATUS_EXHAUSTED;
                  end
               end else begin
                  rsp_id_in = rel_ff;
                  if (mark_rd_data || count_ff[ID_BITS]) begin
                     rsp_status_in = STATUS_DUPLICATE;
                  end else begin
                     rsp_status_in = STATUS_RELEASED;
                     q_wr_en       = 1'b1;
                     tail_in       = tail_ff + 1'b1;
                     count_in      = count_ff + 1'b1;
                     mark_wr_en    = 1'b1;
                     mark_wr_addr  = rel_ff;
                     mark_wr_data  = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_idx_ff   <= '0;
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      rel_ff        <= rel_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire

// ===== design/idal_ram.sv =====
`default_nettype none

module idal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/idal_checker.sv =====
`default_nettype none

module idal_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire idal_pkg::id_type     rsp_id,
   input wire idal_pkg::status_type rsp_status
);
   import idal_pkg::*;

   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_valid && req_ready}
                   - {1'b0, rsp_valid && rsp_ready};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result on offer that is not taken stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id) && $stable(rsp_status))
      else $error("result changed while stalled");

   // Every result belongs to an item that was taken in and not yet answered.
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an outstanding item");

   // At most one item waits in the result register and one is at work.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many items outstanding");

   // An exhausted request reports identifier zero.
   a_exhausted_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EXHAUSTED |-> rsp_id == '0)
      else $error("exhausted result with a non-zero identifier");

   // Reset starts the clearing pass: nothing is taken in or offered.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block active right after reset");

endmodule

bind id_allocator_fifo_free_list_top idal_checker u_idal_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_id     (rsp_chan.id),
   .rsp_status (rsp_chan.status)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
   import idal_pkg::*;

   localparam int QUIET_LIMIT = 6000;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      logic       func;
      id_type     release_id;
      logic       fixed;
      id_type     exp_id;
      status_type exp_status;
   } plan_row_type;

   typedef struct packed {
      id_type     id;
      status_type status;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idal_req_if req_chan();
   idal_rsp_if rsp_chan();

   id_allocator_fifo_free_list_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The expected identifiers below follow from the state after reset.
   plan_row_type opening_plan [23] = '{
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd0,   STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd1,   STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd1023, 1'b1, 10'd2,  STATUS_ISSUED},
      '{FUNC_RELEASE, 10'd1,   1'b1, 10'd1,   STATUS_RELEASED},
      '{FUNC_RELEASE, 10'd1,   1'b1, 10'd1,   STATUS_DUPLICATE},
      '{FUNC_RELEASE, 10'd1023, 1'b1, 10'd1023, STATUS_RELEASED},
      '{FUNC_RELEASE, 10'd1023, 1'b1, 10'd1023, STATUS_DUPLICATE},
      '{FUNC_RELEASE, 10'd0,   1'b1, 10'd0,   STATUS_RELEASED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd1,   STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd1023, STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd0,   STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd3,   STATUS_ISSUED},
      '{FUNC_RELEASE, 10'h2AA, 1'b1, 10'h2AA, STATUS_RELEASED},
      '{FUNC_RELEASE, 10'h155, 1'b1, 10'h155, STATUS_RELEASED},
      '{FUNC_RELEASE, 10'h2AA, 1'b1, 10'h2AA, STATUS_DUPLICATE},
      '{FUNC_REQUEST, 10'h155, 1'b1, 10'h2AA, STATUS_ISSUED},
      '{FUNC_RELEASE, 10'h2AA, 1'b1, 10'h2AA, STATUS_RELEASED},
      '{FUNC_REQUEST, 10'h2AA, 1'b1, 10'h155, STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'h2AA, STATUS_ISSUED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd4,   STATUS_ISSUED},
      '{FUNC_RELEASE, 10'd3,   1'b1, 10'd3,   STATUS_RELEASED},
      '{FUNC_REQUEST, 10'd0,   1'b1, 10'd3,   STATUS_ISSUED},
      '{FUNC_RELEASE, 10'd2,   1'b0, 10'd0,   STATUS_ISSUED}
   };

   count_type  fresh_next = '0;
   id_type     free_ids[$];
   bit         queued [ID_SPACE];
   grant_type  due_grants[$];

   logic       plan_fixed  = 1'b0;
   id_type     plan_id     = '0;
   status_type plan_status = STATUS_ISSUED;
   bit         sender_calm = 1'b0;

   int mismatches    = 0;
   int accepted_in   = 0;
   int results_seen  = 0;
   int issued_count  = 0;
   int released_count = 0;
   int dup_count     = 0;
   int exhaust_count = 0;
   int quiet_cycles  = 0;

   function automatic grant_type allocate_or_release(logic func, id_type rel);
      grant_type g;
      g.id = '0;
      if (func == FUNC_REQUEST) begin
         if (free_ids.size() != 0) begin
            g.id = free_ids[0];
            free_ids.delete(0);
            queued[g.id] = 1'b0;
            g.status = STATUS_ISSUED;
            issued_count++;
         end else if (fresh_next < ID_SPACE) begin
            g.id = fresh_next[ID_BITS-1:0];
            fresh_next = fresh_next + 1'b1;
            g.status = STATUS_ISSUED;
            issued_count++;
         end else begin
            g.status = STATUS_EXHAUSTED;
            exhaust_count++;
         end
      end else begin
         g.id = rel;
         if (queued[rel] || free_ids.size() >= ID_SPACE) begin
            g.status = STATUS_DUPLICATE;
            dup_count++;
         end else begin
            free_ids.push_back(rel);
            queued[rel] = 1'b1;
            g.status = STATUS_RELEASED;
            released_count++;
         end
      end
      return g;
   endfunction

   function automatic int pause_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic id_type pick_release();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20 && free_ids.size() != 0) return free_ids[$urandom_range(0, free_ids.size() - 1)];
      if (r < 80 && fresh_next != 0) return id_type'($urandom_range(0, fresh_next - 1));
      return id_type'($urandom_range(0, ID_SPACE - 1));
   endfunction

   task automatic flag_mismatch(string what, int exp_val, int got_val);
      mismatches++;
      if (mismatches <= 10) begin
         $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $time, exp_val, got_val);
      end
   endtask

   task automatic send_item(logic func, id_type rel, logic fixed, id_type eid,
                            status_type est);
      int gap;
      if (!sender_calm && $urandom_range(0, 99) < 25) begin
         gap = pause_len();
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.release_id <= rel;
      plan_fixed  = fixed;
      plan_id     = eid;
      plan_status = est;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_mix(int n, int release_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 2) sender_calm = !sender_calm;
         if ($urandom_range(0, 99) < release_pct) begin
            send_item(FUNC_RELEASE, pick_release(), 1'b0, '0, STATUS_ISSUED);
         end else begin
            send_item(FUNC_REQUEST, id_type'($urandom_range(0, ID_SPACE - 1)), 1'b0, '0,
                      STATUS_ISSUED);
         end
      end
   endtask

   always @(posedge clock) begin
      grant_type g;
      grant_type e;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            g = allocate_or_release(req_chan.func, req_chan.release_id);
            if (plan_fixed) begin
               g.id     = plan_id;
               g.status = plan_status;
            end
            due_grants.push_back(g);
            accepted_in++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (due_grants.size() == 0) begin
               flag_mismatch("unexpected result, id", -1, rsp_chan.id);
            end else begin
               e = due_grants[0];
               due_grants.delete(0);
               if (rsp_chan.id !== e.id) flag_mismatch("id", e.id, rsp_chan.id);
               if (rsp_chan.status !== e.status) begin
                  flag_mismatch("status", e.status, rsp_chan.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver holds off once for a long stretch so that the block fills up.
   initial begin
      int  stall_left;
      bit  hold_done;
      bit  calm;
      stall_left = 0;
      hold_done  = 1'b0;
      calm       = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) == 0) calm = !calm;
         if (!hold_done && accepted_in >= 250) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 99) < 20) begin
            rsp_chan.ready <= 1'b0;
            stall_left = pause_len() - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.func       = FUNC_REQUEST;
      req_chan.release_id = '0;
      foreach (queued[i]) queued[i] = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         send_item(opening_plan[i].func, opening_plan[i].release_id, opening_plan[i].fixed,
                   opening_plan[i].exp_id, opening_plan[i].exp_status);
      end

      send_mix(60, 40);

      // Use up every fresh identifier and every queued one, then ask past the end.
      while (fresh_next < ID_SPACE || free_ids.size() != 0) begin
         send_item(FUNC_REQUEST, id_type'($urandom_range(0, ID_SPACE - 1)), 1'b0, '0,
                   STATUS_ISSUED);
      end
      repeat (3) send_item(FUNC_REQUEST, '1, 1'b1, '0, STATUS_EXHAUSTED);

      send_mix(60, 50);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_grants.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d transfers in, %0d results: %0d issued, %0d released,",
               accepted_in, results_seen, issued_count, released_count);
      $display("%0d duplicate releases and %0d requests past exhaustion, %0d mismatches.",
               dup_count, exhaust_count, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
